>>> rtl/ilh_pkg.sv
// Package for the inter-arrival log histogram: sizes, codes, the queue entry type,
// and the name cleaning and bucket selection functions.
// No dependencies.
package ilh_pkg;

  localparam int MAX_NAMES   = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int TIME_WIDTH  = 48;

  localparam int NAME_WORDS = 4;
  localparam int WORD_W     = 64;
  localparam int NAME_W     = NAME_WORDS * WORD_W;
  localparam int NAME_BYTES = NAME_W / 8;

  localparam int SLOT_W     = $clog2(MAX_NAMES);
  localparam int FILL_W     = $clog2(MAX_NAMES + 1);
  localparam int BUCKET_W   = 5;
  localparam int CNT_ADDR_W = SLOT_W + BUCKET_W;
  localparam int CNT_DEPTH  = 2 ** CNT_ADDR_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // bucket layout: one decimal digit per decade
  localparam int DIGITS          = 9;
  localparam int STEP_LO_US      = 100000;
  localparam int STEP_MID_US     = 1000000;
  localparam int STEP_HI_US      = 10000000;
  localparam int SPAN_HI_US      = 100000000;
  localparam int BUCKET_MID_BASE = 10;
  localparam int BUCKET_HI_BASE  = 20;
  localparam int BUCKET_TOP      = 30;
  localparam int NUM_BUCKETS     = 31;

  typedef enum logic [1:0] {
    ST_FIRST   = 2'd0,
    ST_COUNTED = 2'd1,
    ST_DROPPED = 2'd2,
    ST_READ    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CLEAN,
    F_MATCH,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_BUCKET,
    B_READ,
    B_UPDATE
  } back_state_e;

  typedef struct packed {
    status_e                 kind;
    logic [SLOT_W-1:0]       slot;
    logic [BUCKET_W-1:0]     bucket;
    logic [TIME_WIDTH-1:0]   now;
    logic                    entry_valid;
  } job_t;

  // every byte after the first zero byte reads as zero
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
    logic [NAME_BYTES-1:0] zf;
    logic [NAME_BYTES-1:0] upto;
    logic [NAME_W-1:0]     keep;
    keep = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      zf[b] = (raw[8*b +: 8] == 8'h00);
    end
    for (int b = 0; b < NAME_BYTES; b++) begin
      upto = NAME_BYTES'((65'd1 << (b + 1)) - 65'd1);
      if ((zf & upto) == '0) begin
        keep[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return keep;
  endfunction

  function automatic logic [BUCKET_W-1:0] pick_bucket(input logic [TIME_WIDTH-1:0] diff);
    logic [DIGITS-1:0]   ge_lo;
    logic [DIGITS-1:0]   ge_mid;
    logic [DIGITS-1:0]   ge_hi;
    logic [BUCKET_W-1:0] b;
    for (int k = 1; k <= DIGITS; k++) begin
      ge_lo[k-1]  = (diff >= TIME_WIDTH'(k * STEP_LO_US));
      ge_mid[k-1] = (diff >= TIME_WIDTH'(k * STEP_MID_US));
      ge_hi[k-1]  = (diff >= TIME_WIDTH'(k * STEP_HI_US));
    end
    if (diff < TIME_WIDTH'(STEP_MID_US)) begin
      b = BUCKET_W'($countones(ge_lo));
    end else if (diff < TIME_WIDTH'(STEP_HI_US)) begin
      b = BUCKET_W'(BUCKET_MID_BASE) + BUCKET_W'($countones(ge_mid));
    end else if (diff < TIME_WIDTH'(SPAN_HI_US)) begin
      b = BUCKET_W'(BUCKET_HI_BASE) + BUCKET_W'($countones(ge_hi));
    end else begin
      b = BUCKET_W'(BUCKET_TOP);
    end
    return b;
  endfunction

endpackage

>>> rtl/ilh_if.sv
// Request and response channel interfaces of the inter-arrival log histogram.
// Depends on ilh_pkg.
interface ilh_req_if import ilh_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [WORD_W-1:0]     ssid_word_0;
  logic [WORD_W-1:0]     ssid_word_1;
  logic [WORD_W-1:0]     ssid_word_2;
  logic [WORD_W-1:0]     ssid_word_3;
  logic [TIME_WIDTH-1:0] arrival_time_us;
  logic [SLOT_W-1:0]     read_entry;
  logic [BUCKET_W-1:0]   read_bucket;

  modport source (
    output valid, req_type, ssid_word_0, ssid_word_1, ssid_word_2, ssid_word_3,
           arrival_time_us, read_entry, read_bucket,
    input  ready
  );
  modport sink (
    input  valid, req_type, ssid_word_0, ssid_word_1, ssid_word_2, ssid_word_3,
           arrival_time_us, read_entry, read_bucket,
    output ready
  );
endinterface

interface ilh_rsp_if import ilh_pkg::*; ;
  logic                   valid;
  logic                   ready;
  status_e                status;
  logic [SLOT_W-1:0]      entry_index;
  logic [BUCKET_W-1:0]    bucket_index;
  logic [COUNT_WIDTH-1:0] bucket_count;
  logic                   entry_valid;

  modport source (
    output valid, status, entry_index, bucket_index, bucket_count, entry_valid,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, bucket_index, bucket_count, entry_valid,
    output ready
  );
endinterface

>>> rtl/ilh_front.sv
// Front end: takes requests, cleans the name, matches it against the name table
// and allocates slots. Emits one job per request. Depends on ilh_pkg, ilh_req_if.
module ilh_front import ilh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilh_req_if.sink    req_i,
  output job_t       job_o,
  output logic       job_valid_o,
  input  logic       job_ready_i
);

  front_state_e          state_q, state_d;
  logic [FILL_W-1:0]     fill_q;
  logic                  type_q;
  logic [NAME_W-1:0]     raw_q;
  logic [NAME_W-1:0]     name_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic [SLOT_W-1:0]     rentry_q;
  logic [BUCKET_W-1:0]   rbucket_q;
  logic [MAX_NAMES-1:0]  hit_q;
  logic [NAME_W-1:0]     name_store_q [MAX_NAMES];

  logic                  accept;
  logic                  push;
  logic                  any_hit;
  logic [SLOT_W-1:0]     hit_slot;
  logic                  full;
  logic                  alloc;

  assign accept = req_i.valid && req_i.ready;
  assign push   = job_valid_o && job_ready_i;
  assign full   = (fill_q >= FILL_W'(MAX_NAMES));
  assign any_hit = |hit_q;
  assign alloc  = push && !type_q && !any_hit && !full;

  always_comb begin
    hit_slot = '0;
    for (int i = MAX_NAMES - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (accept) state_d = F_CLEAN;
      F_CLEAN: state_d = F_MATCH;
      F_MATCH: state_d = F_PUSH;
      F_PUSH:  if (job_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready       = (state_q == F_IDLE);
    job_valid_o       = (state_q == F_PUSH);
    job_o.now         = now_q;
    job_o.bucket      = '0;
    job_o.slot        = '0;
    job_o.entry_valid = 1'b0;
    if (type_q) begin
      job_o.kind        = ST_READ;
      job_o.slot        = rentry_q;
      job_o.bucket      = rbucket_q;
      job_o.entry_valid = (FILL_W'(rentry_q) < fill_q);
    end else if (any_hit) begin
      job_o.kind        = ST_COUNTED;
      job_o.slot        = hit_slot;
      job_o.entry_valid = 1'b1;
    end else if (!full) begin
      job_o.kind        = ST_FIRST;
      job_o.slot        = fill_q[SLOT_W-1:0];
      job_o.entry_valid = 1'b1;
    end else begin
      job_o.kind        = ST_DROPPED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      if (alloc) fill_q <= fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q    <= req_i.req_type;
      raw_q     <= {req_i.ssid_word_3, req_i.ssid_word_2, req_i.ssid_word_1,
                    req_i.ssid_word_0};
      now_q     <= req_i.arrival_time_us;
      rentry_q  <= req_i.read_entry;
      rbucket_q <= req_i.read_bucket;
    end
    if (state_q == F_CLEAN) name_q <= clean_name(raw_q);
    if (state_q == F_MATCH) begin
      for (int i = 0; i < MAX_NAMES; i++) begin
        hit_q[i] <= (FILL_W'(i) < fill_q) && (name_store_q[i] == name_q);
      end
    end
    if (alloc) name_store_q[fill_q[SLOT_W-1:0]] <= name_q;
  end

endmodule

>>> rtl/ilh_queue.sv
// Short job queue between the front and back ends.
// Depends on ilh_pkg.
module ilh_queue import ilh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_job_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output job_t pop_job_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  job_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = slots_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      if (do_pop)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_q] <= push_job_i;
  end

endmodule

>>> rtl/ilh_back.sv
// Back end: interval and bucket, counter read-modify-write, response register.
// Depends on ilh_pkg, ilh_rsp_if.
module ilh_back import ilh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  ilh_rsp_if.source rsp_o
);

  back_state_e            state_q, state_d;
  job_t                   job_q;
  logic [TIME_WIDTH-1:0]  diff_q;
  logic [BUCKET_W-1:0]    bucket_q;
  logic [TIME_WIDTH-1:0]  last_arr_q [MAX_NAMES];
  logic [COUNT_WIDTH-1:0] cnt_mem [CNT_DEPTH];
  logic [CNT_DEPTH-1:0]   cnt_valid_q;
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic                   rhit_q;

  logic                   out_valid_q;
  status_e                out_status_q;
  logic [SLOT_W-1:0]      out_entry_q;
  logic [BUCKET_W-1:0]    out_bucket_q;
  logic [COUNT_WIDTH-1:0] out_count_q;
  logic                   out_evalid_q;

  logic                   take;
  logic                   out_free;
  logic                   retire;
  logic [CNT_ADDR_W-1:0]  addr;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] bumped;

  assign take     = job_valid_i && job_ready_o;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign retire   = (state_q == B_UPDATE) && out_free;
  assign addr     = {job_q.slot, bucket_q};
  assign cur      = rhit_q ? rdata_q : '0;
  assign bumped   = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:   if (job_valid_i) state_d = B_BUCKET;
      B_BUCKET: state_d = B_READ;
      B_READ:   state_d = B_UPDATE;
      B_UPDATE: if (out_free) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o        = (state_q == B_IDLE);
    rsp_o.valid        = out_valid_q;
    rsp_o.status       = out_status_q;
    rsp_o.entry_index  = out_entry_q;
    rsp_o.bucket_index = out_bucket_q;
    rsp_o.bucket_count = out_count_q;
    rsp_o.entry_valid  = out_evalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      cnt_valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (retire)             out_valid_q <= 1'b1;
      else if (rsp_o.ready)   out_valid_q <= 1'b0;
      if (retire && job_q.kind == ST_COUNTED) cnt_valid_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q  <= job_i;
      diff_q <= job_i.now - last_arr_q[job_i.slot];
    end
    if (state_q == B_BUCKET) begin
      bucket_q <= (job_q.kind == ST_READ) ? job_q.bucket : pick_bucket(diff_q);
    end
    if (state_q == B_READ) begin
      rdata_q <= cnt_mem[addr];
      rhit_q  <= cnt_valid_q[addr];
    end
    if (retire) begin
      out_status_q <= job_q.kind;
      out_evalid_q <= job_q.entry_valid;
      case (job_q.kind)
        ST_FIRST: begin
          last_arr_q[job_q.slot] <= job_q.now;
          out_entry_q            <= job_q.slot;
          out_bucket_q           <= '0;
          out_count_q            <= '0;
        end
        ST_COUNTED: begin
          last_arr_q[job_q.slot] <= job_q.now;
          cnt_mem[addr]          <= bumped;
          out_entry_q            <= job_q.slot;
          out_bucket_q           <= bucket_q;
          out_count_q            <= bumped;
        end
        ST_READ: begin
          out_entry_q  <= job_q.slot;
          out_bucket_q <= bucket_q;
          out_count_q  <= (bucket_q < BUCKET_W'(NUM_BUCKETS)) ? cur : '0;
        end
        default: begin
          out_entry_q  <= '0;
          out_bucket_q <= '0;
          out_count_q  <= '0;
        end
      endcase
    end
  end

endmodule

>>> rtl/interarrival_log_histogram.sv
// Top level of the inter-arrival log histogram: front end, job queue, back end.
// Depends on ilh_pkg, ilh_if, ilh_front, ilh_queue, ilh_back.
//
// Beacon events and counter reads enter on req_i and each yields exactly one
// response on rsp_o, in request order. The front end steps through accept, name
// clean, match against the 8-slot name table and hand-off, and takes no new
// request until it is back in idle; the back end (bucket select, counter memory
// read, read-modify-write) runs on the previous request in parallel, behind a
// 2-entry queue. The 256-word counter memory keeps a valid flag per word that
// reset clears at once, so there is no clearing pass.
module interarrival_log_histogram import ilh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ilh_req_if.sink   req_i,
  ilh_rsp_if.source rsp_o
);

  job_t front_job;
  logic front_valid;
  logic front_ready;
  job_t back_job;
  logic back_valid;
  logic back_ready;

  ilh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  ilh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_job_i   (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_job_o    (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  ilh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .rsp_o       (rsp_o)
  );

endmodule

>>> rtl/ilh_checker.sv
// Port-level checks for the inter-arrival log histogram, bound to the top level.
// Depends on ilh_pkg, interarrival_log_histogram.
module ilh_checker import ilh_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input status_e                rsp_status_i,
  input logic [SLOT_W-1:0]      rsp_entry_i,
  input logic [BUCKET_W-1:0]    rsp_bucket_i,
  input logic [COUNT_WIDTH-1:0] rsp_count_i,
  input logic                   rsp_evalid_i
);

  logic [3:0] pend_q;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      pend_q <= pend_q + 4'd1;
    end else if (rsp_xfer && !req_xfer) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({rsp_status_i, rsp_entry_i, rsp_bucket_i, rsp_count_i, rsp_evalid_i}))
    else $error("response changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 4'd0)
    else $error("response without outstanding request");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> !req_ready_i)
    else $error("request accepted while previous one still in front end");

  a_counted_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_COUNTED |->
      rsp_evalid_i && rsp_count_i != '0 &&
      rsp_bucket_i != BUCKET_W'(BUCKET_MID_BASE) &&
      rsp_bucket_i != BUCKET_W'(BUCKET_HI_BASE) &&
      rsp_bucket_i <= BUCKET_W'(BUCKET_TOP))
    else $error("bad counted response");

endmodule

bind interarrival_log_histogram ilh_checker u_ilh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_entry_i  (rsp_o.entry_index),
  .rsp_bucket_i (rsp_o.bucket_index),
  .rsp_count_i  (rsp_o.bucket_count),
  .rsp_evalid_i (rsp_o.entry_valid)
);

>>> dv/tb_interarrival_log_histogram.sv
`timescale 1ns / 100ps
// Self-checking testbench for interarrival_log_histogram: directed and random beacon
// and counter-read traffic with random idling on both channels, checked against a
// local model. Depends on ilh_pkg, ilh_if and the RTL.
module tb_interarrival_log_histogram;
  import ilh_pkg::*;

  localparam logic REQ_BEACON = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam longint unsigned TENTH_SEC_US   = 100000;
  localparam longint unsigned SEC_US         = 1000000;
  localparam longint unsigned TEN_SEC_US     = 10000000;
  localparam longint unsigned HUNDRED_SEC_US = 100000000;
  localparam int              MID_BASE       = 10;
  localparam int              HI_BASE        = 20;
  localparam int              TOP_BUCKET     = 30;

  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 32;

  typedef struct {
    logic                  kind;
    logic [NAME_W-1:0]     ssid;
    logic [TIME_WIDTH-1:0] stamp;
    logic [SLOT_W-1:0]     rd_slot;
    logic [BUCKET_W-1:0]   rd_bucket;
  } beacon_req_t;

  typedef struct {
    status_e                status;
    logic [SLOT_W-1:0]      slot;
    logic [BUCKET_W-1:0]    bucket;
    logic [COUNT_WIDTH-1:0] count;
    logic                   valid;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  ilh_req_if req_ch ();
  ilh_rsp_if rsp_ch ();

  interarrival_log_histogram dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // model state
  logic [NAME_W-1:0]      held_name [MAX_NAMES];
  logic [TIME_WIDTH-1:0]  held_stamp [MAX_NAMES];
  logic [COUNT_WIDTH-1:0] interval_tally [MAX_NAMES][NUM_BUCKETS];
  int unsigned            names_held;

  outcome_t pending_outcomes[$];

  // stimulus bookkeeping
  logic [NAME_W-1:0]     pool_name [MAX_NAMES];
  int                    pool_len [MAX_NAMES];
  logic [TIME_WIDTH-1:0] pool_last [MAX_NAMES];

  bit          idle_mode;
  int unsigned rsp_hold;
  int unsigned fail_count;
  int unsigned status_seen [4];
  outcome_t    want;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("interarrival_log_histogram verification failed");
    $finish;
  end

  function automatic logic [NAME_W-1:0] strip_after_nul(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] kept;
    bit                ended;
    kept  = '0;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) kept[8*b +: 8] = raw[8*b +: 8];
    end
    return kept;
  endfunction

  function automatic logic [BUCKET_W-1:0] interval_bucket(input logic [TIME_WIDTH-1:0] span);
    longint unsigned d;
    d = 64'(span);
    if (d < SEC_US) return BUCKET_W'(d / TENTH_SEC_US);
    if (d < TEN_SEC_US) return BUCKET_W'(d / SEC_US + MID_BASE);
    if (d < HUNDRED_SEC_US) return BUCKET_W'(d / TEN_SEC_US + HI_BASE);
    return BUCKET_W'(TOP_BUCKET);
  endfunction

  function automatic outcome_t histogram_outcome(input beacon_req_t r);
    outcome_t              o;
    logic [NAME_W-1:0]     name;
    logic [BUCKET_W-1:0]   b;
    int                    hit;
    o.status = ST_DROPPED;
    o.slot   = '0;
    o.bucket = '0;
    o.count  = '0;
    o.valid  = 1'b0;
    if (r.kind == REQ_READ) begin
      o.status = ST_READ;
      o.slot   = r.rd_slot;
      o.bucket = r.rd_bucket;
      if (r.rd_bucket < NUM_BUCKETS) o.count = interval_tally[r.rd_slot][r.rd_bucket];
      o.valid = (r.rd_slot < names_held);
      return o;
    end
    name = strip_after_nul(r.ssid);
    hit  = -1;
    for (int i = 0; i < names_held; i++) begin
      if (hit < 0 && held_name[i] == name) hit = i;
    end
    if (hit < 0) begin
      if (names_held >= MAX_NAMES) return o;
      held_name[names_held]  = name;
      held_stamp[names_held] = r.stamp;
      o.status = ST_FIRST;
      o.slot   = SLOT_W'(names_held);
      o.valid  = 1'b1;
      names_held++;
      return o;
    end
    b = interval_bucket(r.stamp - held_stamp[hit]);
    held_stamp[hit] = r.stamp;
    if (interval_tally[hit][b] != '1) interval_tally[hit][b]++;
    o.status = ST_COUNTED;
    o.slot   = SLOT_W'(hit);
    o.bucket = b;
    o.count  = interval_tally[hit][b];
    o.valid  = 1'b1;
    return o;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic beacon_req_t noise_req();
    beacon_req_t r;
    r.kind      = 1'($urandom_range(0, 1));
    r.ssid      = {random_word(), random_word(), random_word(), random_word()};
    r.stamp     = TIME_WIDTH'({$urandom, $urandom});
    r.rd_slot   = SLOT_W'($urandom_range(0, MAX_NAMES - 1));
    r.rd_bucket = BUCKET_W'($urandom_range(0, 31));
    return r;
  endfunction

  function automatic logic [NAME_W-1:0] make_name(input int len);
    logic [NAME_W-1:0] n;
    n = '0;
    for (int b = 0; b < len; b++) n[8*b +: 8] = 8'($urandom_range(1, 255));
    return n;
  endfunction

  // junk after the terminating NUL must not affect matching
  function automatic logic [NAME_W-1:0] dress_name(input logic [NAME_W-1:0] name, input int len);
    logic [NAME_W-1:0] n;
    n = name;
    for (int b = len + 1; b < NAME_BYTES; b++) n[8*b +: 8] = 8'($urandom_range(0, 255));
    return n;
  endfunction

  function automatic logic [TIME_WIDTH-1:0] pick_interval();
    int region;
    region = $urandom_range(0, 9);
    case (region)
      0, 1, 2: begin
        return TIME_WIDTH'($urandom_range(0, SEC_US - 1));
      end
      3, 4, 5: begin
        return TIME_WIDTH'($urandom_range(SEC_US, TEN_SEC_US - 1));
      end
      6, 7: begin
        return TIME_WIDTH'($urandom_range(TEN_SEC_US, HUNDRED_SEC_US - 1));
      end
      8: begin
        return TIME_WIDTH'({$urandom, $urandom});
      end
      default: begin
        return TIME_WIDTH'($urandom_range(0, 1) ? HUNDRED_SEC_US : 0);
      end
    endcase
  endfunction

  task automatic send_req(input beacon_req_t r);
    int gap;
    gap = (idle_mode && $urandom_range(0, 1) == 0) ? idle_span() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= r.kind;
    req_ch.ssid_word_0     <= r.ssid[0*WORD_W +: WORD_W];
    req_ch.ssid_word_1     <= r.ssid[1*WORD_W +: WORD_W];
    req_ch.ssid_word_2     <= r.ssid[2*WORD_W +: WORD_W];
    req_ch.ssid_word_3     <= r.ssid[3*WORD_W +: WORD_W];
    req_ch.arrival_time_us <= r.stamp;
    req_ch.read_entry      <= r.rd_slot;
    req_ch.read_bucket     <= r.rd_bucket;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    pending_outcomes.push_back(histogram_outcome(r));
  endtask

  task automatic send_known(input int k, input logic [TIME_WIDTH-1:0] interval);
    beacon_req_t r;
    r       = noise_req();
    r.kind  = REQ_BEACON;
    r.ssid  = dress_name(pool_name[k], pool_len[k]);
    r.stamp = pool_last[k] + interval;
    pool_last[k] = r.stamp;
    send_req(r);
  endtask

  task automatic send_read(input int slot, input int bucket);
    beacon_req_t r;
    r           = noise_req();
    r.kind      = REQ_READ;
    r.rd_slot   = SLOT_W'(slot);
    r.rd_bucket = BUCKET_W'(bucket);
    send_req(r);
  endtask

  task automatic test_empty_reads();
    send_read(0, 0);
    send_read(MAX_NAMES - 1, TOP_BUCKET);
    send_read(3, 31);
  endtask

  task automatic test_first_sightings();
    int lens [MAX_NAMES];
    lens = '{0, NAME_BYTES, 1, 5, 8, 9, 17, 24};
    for (int k = 0; k < MAX_NAMES; k++) begin
      pool_len[k]  = lens[k];
      pool_name[k] = make_name(lens[k]);
      pool_last[k] = TIME_WIDTH'({$urandom, $urandom});
    end
    pool_name[1][7:0] = 8'hFF;
    for (int k = 0; k < MAX_NAMES; k++) begin
      send_known(k, '0);
      if (k == 3) send_read(6, 5);
    end
  endtask

  task automatic test_bucket_edges();
    logic [TIME_WIDTH-1:0] edges [10];
    edges = '{'0, TIME_WIDTH'(TENTH_SEC_US - 1), TIME_WIDTH'(TENTH_SEC_US),
              TIME_WIDTH'(SEC_US - 1), TIME_WIDTH'(SEC_US), TIME_WIDTH'(TEN_SEC_US - 1),
              TIME_WIDTH'(TEN_SEC_US), TIME_WIDTH'(HUNDRED_SEC_US - 1),
              TIME_WIDTH'(HUNDRED_SEC_US), '1};
    foreach (edges[i]) send_known(i % 2 == 0 ? 1 : 2, edges[i]);
    send_read(1, TOP_BUCKET);
    send_read(MAX_NAMES - 1, 31);
  endtask

  task automatic test_table_full();
    beacon_req_t r;
    r      = noise_req();
    r.kind = REQ_BEACON;
    r.ssid = dress_name(make_name(3), 3);
    send_req(r);
  endtask

  task automatic test_random_traffic(input int total);
    beacon_req_t r;
    int          pick;
    for (int n = 0; n < total; n++) begin
      if (n % 250 == 0) idle_mode = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_known($urandom_range(0, MAX_NAMES - 1), pick_interval());
      end else if (pick < 80) begin
        r      = noise_req();
        r.kind = REQ_BEACON;
        send_req(r);
      end else begin
        r      = noise_req();
        r.kind = REQ_READ;
        send_req(r);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!idle_mode) begin
      rsp_ch.ready <= 1'b1;
    end else if (rsp_hold != 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold     <= rsp_hold - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold     <= idle_span() - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $error("response transfer with no request outstanding");
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        status_seen[want.status]++;
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.entry_index !== want.slot) begin
          $error("entry_index: expected %0d, got %0d", want.slot, rsp_ch.entry_index);
          fail_count++;
        end
        if (rsp_ch.bucket_index !== want.bucket) begin
          $error("bucket_index: expected %0d, got %0d", want.bucket, rsp_ch.bucket_index);
          fail_count++;
        end
        if (rsp_ch.bucket_count !== want.count) begin
          $error("bucket_count: expected %0d, got %0d", want.count, rsp_ch.bucket_count);
          fail_count++;
        end
        if (rsp_ch.entry_valid !== want.valid) begin
          $error("entry_valid: expected %0d, got %0d", want.valid, rsp_ch.entry_valid);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_ni                 = 1'b0;
    req_ch.valid           = 1'b0;
    req_ch.req_type        = REQ_BEACON;
    req_ch.ssid_word_0     = '0;
    req_ch.ssid_word_1     = '0;
    req_ch.ssid_word_2     = '0;
    req_ch.ssid_word_3     = '0;
    req_ch.arrival_time_us = '0;
    req_ch.read_entry      = '0;
    req_ch.read_bucket     = '0;
    rsp_ch.ready           = 1'b0;
    rsp_hold               = 0;
    idle_mode              = 1'b1;
    fail_count             = 0;
    names_held             = 0;
    status_seen            = '{0, 0, 0, 0};
    for (int s = 0; s < MAX_NAMES; s++) begin
      for (int b = 0; b < NUM_BUCKETS; b++) interval_tally[s][b] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_reads();
    test_first_sightings();
    test_bucket_edges();
    test_table_full();
    test_random_traffic(RANDOM_ITEMS);
    req_ch.valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d first sightings, %0d counted intervals, %0d dropped beacons,",
             status_seen[ST_FIRST], status_seen[ST_COUNTED], status_seen[ST_DROPPED]);
    $display("and %0d counter reads, with random stalls on both channels.",
             status_seen[ST_READ]);
    if (fail_count == 0) begin
      $display("interarrival_log_histogram verification clean");
    end else begin
      $display("interarrival_log_histogram verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ilh_pkg.sv
rtl/ilh_if.sv
rtl/ilh_front.sv
rtl/ilh_queue.sv
rtl/ilh_back.sv
rtl/interarrival_log_histogram.sv
rtl/ilh_checker.sv
dv/tb_interarrival_log_histogram.sv
